### rtl/key_press_length_classifier_top_defines.svh
// Assertion macros shared by the key press length classifier RTL.
`ifndef KEY_PRESS_LENGTH_CLASSIFIER_TOP_DEFINES_SVH
`define KEY_PRESS_LENGTH_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset
`define KPLC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("kplc invariant violated");
// Antecedent at one edge implies consequent at the next edge
`define KPLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kplc sequence violated");
`else
`define KPLC_ASSERT_ALWAYS(lbl, cond)
`define KPLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/kplc_pkg.sv
// Types and constants of the key press length classifier.
package kplc_pkg;

    localparam int unsigned LINE_COUNT = 4;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned GAP_W      = 6;

    typedef logic [2:0]       key_id_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam key_id_t NO_KEY = 3'd4;

    // Item kind carried on tuser
    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_ACK  = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SHORT_THR   = 2'd0,
        CFG_LONG_THR    = 2'd1,
        CFG_REPEAT_GAP  = 2'd2,
        CFG_COUNTER_CAP = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        count_t           short_thr;
        count_t           long_thr;
        logic [GAP_W-1:0] repeat_gap;
        count_t           counter_cap;
    } cfg_t;

    // Release search link: lowest rising key wins
    typedef struct packed {
        logic    seen;
        key_id_t rel;
        key_id_t long_rel;
    } rel_link_t;

    // Counting link: highest qualifying key wins
    typedef struct packed {
        key_id_t press;
        key_id_t long_press;
    } cnt_link_t;

endpackage

### rtl/kplc_cell.sv
// One key cell: hold counter plus its stage of the release and counting chains.
module kplc_cell #(
    parameter kplc_pkg::key_id_t KEY_ID = 3'd0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic                line_now,
    input  logic                line_prev,
    input  kplc_pkg::cfg_t      cfg,
    input  kplc_pkg::rel_link_t rel_in,
    output kplc_pkg::rel_link_t rel_out,
    input  kplc_pkg::cnt_link_t cnt_in,
    output kplc_pkg::cnt_link_t cnt_out
);
    import kplc_pkg::*;

    count_t     hold_count_reg;
    count_t     hold_count_next;
    count_t     inc_count;
    logic       rising;
    logic       first_rise;
    logic       hit_press;
    logic       hit_long;
    logic [8:0] long_fire;

    // Release search stage
    always_comb begin
        rising     = line_now & ~line_prev;
        first_rise = rising & ~rel_in.seen;
        rel_out.seen = rel_in.seen | rising;
        rel_out.rel  = (first_rise && hold_count_reg > cfg.short_thr
                        && hold_count_reg < cfg.long_thr) ? KEY_ID : rel_in.rel;
        rel_out.long_rel = (first_rise && hold_count_reg > cfg.long_thr)
                           ? KEY_ID : rel_in.long_rel;
    end

    // Counting stage
    always_comb begin
        inc_count = (hold_count_reg < cfg.counter_cap) ? hold_count_reg + 8'd1
                                                       : hold_count_reg;
        long_fire = {1'b0, cfg.long_thr} + {3'b000, cfg.repeat_gap};
        hit_press = !line_now && (inc_count == cfg.short_thr);
        hit_long  = !line_now && ({1'b0, inc_count} == long_fire);
        cnt_out.press      = hit_press ? KEY_ID : cnt_in.press;
        cnt_out.long_press = hit_long  ? KEY_ID : cnt_in.long_press;
        if (line_now) begin
            hold_count_next = '0;
        end else if (hit_long) begin
            hold_count_next = cfg.long_thr + 8'd1;
        end else begin
            hold_count_next = inc_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_count_reg <= '0;
        end else if (step_en) begin
            hold_count_reg <= hold_count_next;
        end
    end

endmodule

### rtl/key_press_length_classifier_top.sv
// Results are registered: in the output register, or the skid entry on a stall.
// Throughput: one item per cycle while s_tready is high; cells run in parallel.
// A two-entry output buffer keeps input transfers going while a result waits.
// Reset (aresetn low, synchronous): counters zero, key lines released,
// all events none, configuration at its defaults, output buffer empty.
`include "key_press_length_classifier_top_defines.svh"

module key_press_length_classifier_top #(
    parameter int unsigned KEY_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_lines[3:0], clear_mask[7:4]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pressed_key[2:0], released_key[5:3],
                                   // long_pressed_key[8:6], long_released_key[11:9]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import kplc_pkg::*;

    cfg_t                  cfg_reg;
    logic [LINE_COUNT-1:0] previous_lines_reg;
    key_id_t               press_reg, release_reg, long_press_reg, long_release_reg;
    key_id_t               press_next, release_next, long_press_next, long_release_next;
    logic [15:0]           out_data_reg, skid_data_reg, result_word;
    logic                  out_valid_reg, skid_valid_reg;

    logic                  s_xfer, m_xfer, scan_xfer, ack_xfer;
    logic                  search_en, count_en, step_en;
    logic [LINE_COUNT-1:0] key_lines, clear_mask;
    key_id_t               rel_found, long_rel_found;

    rel_link_t rel_chain [KEY_COUNT+1];
    cnt_link_t cnt_chain [KEY_COUNT+1];

    assign s_tready   = !skid_valid_reg;
    assign s_xfer     = s_tvalid && s_tready;
    assign m_xfer     = m_tvalid && m_tready;
    assign scan_xfer  = s_xfer && (op_t'(s_tuser[0]) == OP_SCAN);
    assign ack_xfer   = s_xfer && (op_t'(s_tuser[0]) == OP_ACK);
    assign key_lines  = s_tdata[LINE_COUNT-1:0];
    assign clear_mask = s_tdata[2*LINE_COUNT-1:LINE_COUNT];

    // Chain heads
    assign rel_chain[0] = '{seen: 1'b0, rel: NO_KEY, long_rel: NO_KEY};
    assign cnt_chain[0] = '{press: press_reg, long_press: long_press_reg};

    // Row of key cells; keys without a line stay released
    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_cell
        logic line_now, line_prev;
        if (k < LINE_COUNT) begin : g_line
            assign line_now  = key_lines[k];
            assign line_prev = previous_lines_reg[k];
        end else begin : g_noline
            assign line_now  = 1'b1;
            assign line_prev = 1'b1;
        end
        kplc_cell #(
            .KEY_ID (3'(k))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step_en   (step_en),
            .line_now  (line_now),
            .line_prev (line_prev),
            .cfg       (cfg_reg),
            .rel_in    (rel_chain[k]),
            .rel_out   (rel_chain[k+1]),
            .cnt_in    (cnt_chain[k]),
            .cnt_out   (cnt_chain[k+1])
        );
    end

    // Event update: release search first, then counting gated by the new release
    always_comb begin
        rel_found      = rel_chain[KEY_COUNT].rel;
        long_rel_found = rel_chain[KEY_COUNT].long_rel;
        search_en = (release_reg == NO_KEY) && (long_release_reg == NO_KEY);
        press_next        = press_reg;
        release_next      = release_reg;
        long_press_next   = long_press_reg;
        long_release_next = long_release_reg;
        if (search_en) begin
            release_next      = rel_found;
            long_release_next = long_rel_found;
        end
        count_en = (release_next == NO_KEY) && (long_press_reg == NO_KEY);
        step_en  = scan_xfer && count_en;
        if (count_en) begin
            press_next      = cnt_chain[KEY_COUNT].press;
            long_press_next = cnt_chain[KEY_COUNT].long_press;
        end
        if (ack_xfer) begin
            press_next        = clear_mask[0] ? NO_KEY : press_reg;
            release_next      = clear_mask[1] ? NO_KEY : release_reg;
            long_press_next   = clear_mask[2] ? NO_KEY : long_press_reg;
            long_release_next = clear_mask[3] ? NO_KEY : long_release_reg;
        end
        result_word = {4'b0000, long_release_next, long_press_next,
                       release_next, press_next};
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_lines_reg <= '1;
            press_reg          <= NO_KEY;
            release_reg        <= NO_KEY;
            long_press_reg     <= NO_KEY;
            long_release_reg   <= NO_KEY;
        end else if (s_xfer) begin
            press_reg        <= press_next;
            release_reg      <= release_next;
            long_press_reg   <= long_press_next;
            long_release_reg <= long_release_next;
            if (scan_xfer) begin
                previous_lines_reg <= key_lines;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{short_thr: 8'd2, long_thr: 8'd60, repeat_gap: 6'd6,
                         counter_cap: 8'd230};
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_SHORT_THR:   cfg_reg.short_thr   <= cfg_wdata;
                CFG_LONG_THR:    cfg_reg.long_thr    <= cfg_wdata;
                CFG_REPEAT_GAP:  cfg_reg.repeat_gap  <= cfg_wdata[GAP_W-1:0];
                CFG_COUNTER_CAP: cfg_reg.counter_cap <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Two-entry output buffer: output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_xfer || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= s_xfer;
            end else begin
                out_valid_reg  <= s_xfer;
            end
        end else if (s_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_xfer || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                if (s_xfer) begin
                    skid_data_reg <= result_word;
                end
            end else if (s_xfer) begin
                out_data_reg <= result_word;
            end
        end else if (s_xfer) begin
            skid_data_reg <= result_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `KPLC_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `KPLC_ASSERT_NEXT(a_stall_fills_skid, s_xfer && m_tvalid && !m_tready, skid_valid_reg)
    `KPLC_ASSERT_NEXT(a_result_follows, s_xfer, m_tvalid)
    `KPLC_ASSERT_ALWAYS(a_one_release_kind,
        (release_reg == NO_KEY) || (long_release_reg == NO_KEY))
    `KPLC_ASSERT_NEXT(a_full_ack_clears, ack_xfer && (clear_mask == 4'hF),
        (press_reg == NO_KEY) && (release_reg == NO_KEY)
        && (long_press_reg == NO_KEY) && (long_release_reg == NO_KEY))

endmodule
